// ===== hw/rtl/xges_pkg.sv =====
// Shared types and constants for the x86 gadget effect scanner.
package xges_pkg;

    // Opcode bytes that the scanner recognizes.
    localparam logic [7:0] OP_POP_LO  = 8'h58;
    localparam logic [7:0] OP_POP_HI  = 8'h5F;
    localparam logic [7:0] OP_REX_B   = 8'h41;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_RET_IMM = 8'hC2;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_SYSCALL = 8'h05;
    localparam logic [7:0] OP_INT3    = 8'hCC;
    localparam logic [7:0] OP_GRP5    = 8'hFF;

    localparam int unsigned MASK_W  = 16;
    localparam int unsigned STACK_W = 17;
    localparam logic [STACK_W-1:0] STACK_MAX = {STACK_W{1'b1}};
    localparam logic [STACK_W-1:0] POP_BYTES = STACK_W'(8);

    // Depth of the result queue in front of the output port.
    localparam int unsigned OUT_DEPTH = 2;

    typedef enum logic [2:0] {
        TK_NONE    = 3'd0,
        TK_RET     = 3'd1,
        TK_SYSCALL = 3'd2,
        TK_INT3    = 3'd3,
        TK_CALLREG = 3'd4,
        TK_JMPREG  = 3'd5
    } t_term;

    // One fragment summary.
    typedef struct packed {
        logic [MASK_W-1:0]  register_writes;
        logic [STACK_W-1:0] stack_bytes;
        t_term              terminator_kind;
        logic               syscall_flag;
    } t_result;

endpackage

// ===== hw/rtl/xges_scan.sv =====
// Per-byte decode state machine that accumulates one fragment summary.
module xges_scan
    import xges_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_code_byte,
    input  logic       i_last_byte,
    output logic       o_result_valid,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_REX    = 3'd1,
        M_IMM_LO = 3'd2,
        M_IMM_HI = 3'd3,
        M_ESC    = 3'd4,
        M_MODRM  = 3'd5,
        M_DONE   = 3'd6,
        M_FAIL   = 3'd7
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic [STACK_W-1:0] r_stack, n_stack;
    t_term              r_term, n_term;
    logic [7:0]         r_imm, n_imm;

    logic               is_pop;
    logic               add_en;
    logic [STACK_W-1:0] add_amount;
    logic [STACK_W:0]   stack_sum;
    logic [STACK_W-1:0] stack_sat;
    logic [2:0]         modrm_reg;
    logic               ok;

    assign is_pop    = (i_code_byte >= OP_POP_LO) && (i_code_byte <= OP_POP_HI);
    assign modrm_reg = i_code_byte[5:3];

    // Saturating stack accumulator shared by every form that consumes stack.
    assign stack_sum = {1'b0, r_stack} + {1'b0, add_amount};
    assign stack_sat = stack_sum[STACK_W] ? STACK_MAX : stack_sum[STACK_W-1:0];

    // Next-state decode for one byte.
    always_comb begin
        n_mode     = r_mode;
        n_mask     = r_mask;
        n_term     = r_term;
        n_imm      = r_imm;
        add_en     = 1'b0;
        add_amount = POP_BYTES;
        unique case (r_mode)
            M_NORMAL: begin
                if (is_pop) begin
                    n_mask = r_mask | (MASK_W'(1) << {1'b0, i_code_byte[2:0]});
                    add_en = 1'b1;
                end else if (i_code_byte == OP_REX_B) begin
                    n_mode = M_REX;
                end else if (i_code_byte == OP_RET) begin
                    add_en = 1'b1;
                    n_term = TK_RET;
                    n_mode = M_DONE;
                end else if (i_code_byte == OP_RET_IMM) begin
                    n_mode = M_IMM_LO;
                end else if (i_code_byte == OP_ESC) begin
                    n_mode = M_ESC;
                end else if (i_code_byte == OP_INT3) begin
                    n_term = TK_INT3;
                    n_mode = M_DONE;
                end else if (i_code_byte == OP_GRP5) begin
                    n_mode = M_MODRM;
                end else begin
                    n_mode = M_FAIL;
                end
            end
            M_REX: begin
                if (is_pop) begin
                    n_mask = r_mask | (MASK_W'(1) << {1'b1, i_code_byte[2:0]});
                    add_en = 1'b1;
                    n_mode = M_NORMAL;
                end else begin
                    n_mode = M_FAIL;
                end
            end
            M_IMM_LO: begin
                n_imm  = i_code_byte;
                n_mode = M_IMM_HI;
            end
            M_IMM_HI: begin
                add_en     = 1'b1;
                add_amount = {1'b0, i_code_byte, r_imm} + POP_BYTES;
                n_term     = TK_RET;
                n_mode     = M_DONE;
            end
            M_ESC: begin
                if (i_code_byte == OP_SYSCALL) begin
                    n_term = TK_SYSCALL;
                    n_mode = M_DONE;
                end else begin
                    n_mode = M_FAIL;
                end
            end
            M_MODRM: begin
                case (modrm_reg) inside
                    3'd2, 3'd3: n_term = TK_CALLREG;
                    3'd4, 3'd5: n_term = TK_JMPREG;
                    default:    n_term = TK_NONE;
                endcase
                n_mode = M_DONE;
            end
            M_DONE: begin
            end
            M_FAIL: begin
            end
        endcase
        n_stack = add_en ? stack_sat : r_stack;
        if (n_mode == M_FAIL) begin
            n_mask  = '0;
            n_stack = '0;
            n_term  = TK_NONE;
        end
    end

    // A fragment's summary is zero unless the fragment ends in a complete form.
    assign ok = (n_mode == M_NORMAL) || (n_mode == M_DONE);

    always_comb begin
        o_result_valid = i_accept && i_last_byte;
        if (ok) begin
            o_result.register_writes = n_mask;
            o_result.stack_bytes     = n_stack;
            o_result.terminator_kind = n_term;
            o_result.syscall_flag    = (n_term == TK_SYSCALL);
        end else begin
            o_result.register_writes = '0;
            o_result.stack_bytes     = '0;
            o_result.terminator_kind = TK_NONE;
            o_result.syscall_flag    = 1'b0;
        end
    end

    // State registers; the last byte returns the scanner to its idle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_mask  <= '0;
            r_stack <= '0;
            r_term  <= TK_NONE;
            r_imm   <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_mode  <= M_NORMAL;
                r_mask  <= '0;
                r_stack <= '0;
                r_term  <= TK_NONE;
                r_imm   <= '0;
            end else begin
                r_mode  <= n_mode;
                r_mask  <= n_mask;
                r_stack <= n_stack;
                r_term  <= n_term;
                r_imm   <= n_imm;
            end
        end
    end

endmodule

// ===== hw/rtl/xges_out_queue.sv =====
// Small result queue that registers summaries toward the output port.
module xges_out_queue
    import xges_pkg::*;
#(
    parameter int unsigned DEPTH = OUT_DEPTH
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage for pending results.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/x86_gadget_effect_scanner_unit.sv =====
// Top level of the x86 gadget effect scanner.
// The unit takes one code byte per transaction and emits one summary per fragment at the
// byte marked last: the mask of popped registers, saturating stack bytes consumed, the
// terminator kind and a syscall flag, all zero when the fragment holds an unknown byte or
// ends inside a multi-byte form. The per-byte mode update and the single saturating stack
// add sit between the scanner state registers and a two-entry result queue, so a byte is
// accepted in every cycle while the queue has room, including while one finished summary
// still waits to be taken. The summary of a fragment appears at the output in the cycle
// after its last byte is accepted when no earlier summary is waiting; otherwise it follows
// the summaries ahead of it in the queue.
module x86_gadget_effect_scanner_unit
    import xges_pkg::*;
#(
    parameter int unsigned OUT_QUEUE_DEPTH = OUT_DEPTH
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_code_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MASK_W-1:0]  o_register_writes,
    output logic [STACK_W-1:0] o_stack_bytes,
    output logic [2:0]         o_terminator_kind,
    output logic               o_syscall_flag
);

    logic    accept;
    logic    queue_full;
    logic    result_valid;
    t_result result;
    t_result out_data;

    // A byte is taken whenever the result queue can absorb a summary.
    assign o_ready = !queue_full;
    assign accept  = i_valid && o_ready;

    xges_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_code_byte    (i_code_byte),
        .i_last_byte    (i_last_byte),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    xges_out_queue #(
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_valid),
        .i_data  (result),
        .o_full  (queue_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    // Unpack the summary onto the output ports.
    assign o_register_writes = out_data.register_writes;
    assign o_stack_bytes     = out_data.stack_bytes;
    assign o_terminator_kind = out_data.terminator_kind;
    assign o_syscall_flag    = out_data.syscall_flag;

endmodule
